>>> hdl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int unsigned FIELD_BITS = 32;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_CMP = 3'd4,
    MODE_INV = 3'd5
  } mode_code_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [FIELD_BITS-1:0] a_num;
    logic signed [FIELD_BITS-1:0] a_den;
    logic signed [FIELD_BITS-1:0] b_num;
    logic signed [FIELD_BITS-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] res_num;
    logic signed [FIELD_BITS-1:0] res_den;
    logic [1:0]               order;
    logic [1:0]               status;
  } rau_out_t;

  // datapath operations driven by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // capture operands
    OP_GCD_INIT,  // load gcd unit from selected pair
    OP_GCD_STEP,  // one subtract/shift step
    OP_DIV_INIT,  // start dividing selected value by gcd
    OP_DIV_STEP,  // one restoring division bit
    OP_DIV_SAVE,  // store quotient into selected slot
    OP_MUL1,      // first product
    OP_MUL2,      // second product
    OP_ADDSUB,    // combine cross products
    OP_CMP,       // compare result
    OP_FINISH     // sign fix and range check
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] sel;  // operand/slot selector
  } rau_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic early;      // result settled by a fast path or error
  } rau_stat_t;

endpackage

>>> hdl/rau_datapath.sv
// datapath: operand registers, binary gcd, restoring divider, multiplier
module rau_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::rau_in_t  in_data,
  input  rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_out_t result
);
  import rau_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned WW = 2 * WORD_BITS + 2;
  localparam int unsigned CW = $clog2(WW + 1);

  logic [2:0] mode_r;
  logic signed [W:0] an_r, ad_r, bn_r, bd_r;     // one spare bit
  logic signed [WW-1:0] n_r, d_r;                // working numerator / denominator
  logic [1:0] st_r, st_nxt;
  logic [1:0] ord_r;
  logic early_r;

  // gcd unit on magnitudes
  logic [WW-1:0] gx_r, gy_r;
  logic [CW-1:0] gk_r;
  // divider
  logic [WW-1:0] dq_r, drem_r, ddiv_r;
  logic [CW-1:0] dcnt_r;
  logic          dneg_r;
  logic [WW-1:0] g_val;

  function automatic logic signed [W:0] sx(input logic [FIELD_BITS-1:0] v);
    return (W+1)'(signed'(v[W-1:0]));
  endfunction

  function automatic logic [WW-1:0] magw(input logic signed [WW-1:0] v);
    return v[WW-1] ? WW'(-v) : WW'(v);
  endfunction

  function automatic logic signed [WW-1:0] ext(input logic signed [W:0] v);
    return WW'(v);
  endfunction

  logic signed [W:0] lo_lim, hi_lim;
  assign hi_lim = (W+1)'((1 << (W-1)) - 1);
  assign lo_lim = -hi_lim - (W+1)'(1);

  function automatic logic in_rng(input logic signed [WW-1:0] v,
                                  input logic signed [W:0] lo,
                                  input logic signed [W:0] hi);
    return (v >= WW'(lo)) && (v <= WW'(hi));
  endfunction

  // selected source pair for gcd and value for division
  logic signed [WW-1:0] src_a, src_b, div_src;
  always_comb begin
    src_a = '0;
    src_b = '0;
    case (cmd.sel)
      3'd0: begin src_a = ext(an_r); src_b = ext(bd_r); end
      3'd1: begin src_a = ext(ad_r); src_b = ext(bn_r); end
      3'd2: begin src_a = ext(an_r); src_b = ext(bn_r); end
      3'd3: begin src_a = ext(ad_r); src_b = ext(bd_r); end
      default: begin src_a = n_r; src_b = d_r; end
    endcase
  end
  always_comb begin
    case (cmd.sel)
      3'd0: div_src = ext(an_r);
      3'd1: div_src = ext(ad_r);
      3'd2: div_src = ext(bn_r);
      3'd3: div_src = ext(bd_r);
      3'd4: div_src = n_r;
      default: div_src = d_r;
    endcase
  end

  assign g_val = (gx_r == '0) ? WW'(1) : (gx_r << gk_r);

  logic [WW-1:0] rem_sh, rem_sub;
  assign rem_sh  = {drem_r[WW-2:0], dq_r[WW-1]};
  assign rem_sub = rem_sh - ddiv_r;

  logic signed [W:0] m_a, m_b;
  logic signed [WW-1:0] prod;
  assign prod = ext(m_a) * ext(m_b);

  always_comb begin
    m_a = '0;
    m_b = '0;
    unique case (cmd.op)
      OP_MUL1: begin
        case (mode_r) inside
          MODE_ADD, MODE_SUB, MODE_CMP: begin m_a = an_r; m_b = bd_r; end
          MODE_MUL: begin m_a = an_r; m_b = bn_r; end
          default: begin m_a = an_r; m_b = bd_r; end
        endcase
      end
      OP_MUL2: begin
        case (mode_r) inside
          MODE_ADD, MODE_SUB, MODE_CMP: begin m_a = bn_r; m_b = ad_r; end
          MODE_MUL: begin m_a = ad_r; m_b = bd_r; end
          default: begin m_a = ad_r; m_b = bn_r; end
        endcase
      end
      default: ;
    endcase
  end

  logic signed [WW-1:0] sum;
  assign sum = (mode_r == MODE_SUB) ? n_r - d_r : n_r + d_r;
  logic signed [WW-1:0] fn, fd;
  assign fn = d_r[WW-1] ? -n_r : n_r;
  assign fd = d_r[WW-1] ? -d_r : d_r;

  // early decisions at load
  logic signed [W:0] ian, iad, ibn, ibd;
  logic [2:0] imode;
  assign imode = in_data.mode;
  assign ian = sx(in_data.a_num);
  assign iad = sx(in_data.a_den);
  assign ibn = sx(in_data.b_num);
  assign ibd = sx(in_data.b_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      early_r <= 1'b0;
      st_r    <= ST_OK;
      ord_r   <= ORD_LESS;
      mode_r  <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          mode_r  <= imode;
          an_r <= ian; ad_r <= iad; bn_r <= ibn; bd_r <= ibd;
          st_r    <= ST_OK;
          ord_r   <= ORD_LESS;
          early_r <= 1'b1;
          n_r     <= '0;
          d_r     <= WW'(1);
          if (imode > 3'd5) begin
          end else if (iad == 0 || (imode != MODE_INV && ibd == 0)) begin
            st_r <= ST_DIV0;
          end else if (imode == MODE_ADD || imode == MODE_SUB) begin
            if (ibn == 0) begin
              n_r <= ext(ian); d_r <= ext(iad);
            end else if (imode == MODE_ADD && ian == 0) begin
              n_r <= ext(ibn); d_r <= ext(ibd);
            end else early_r <= 1'b0;
          end else if (imode == MODE_MUL) begin
            if (ian != 0 && ibn != 0) early_r <= 1'b0;
          end else if (imode == MODE_DIV) begin
            if (ibn == 0) st_r <= ST_DIV0;
            else early_r <= 1'b0;
          end else if (imode == MODE_CMP) begin
            early_r <= 1'b0;
          end else begin
            if (ian == 0) st_r <= ST_DIV0;
            else begin
              early_r <= 1'b0;
              n_r <= ext(iad); d_r <= ext(ian);
            end
          end
        end
        OP_GCD_INIT: begin
          gx_r <= magw(src_a);
          gy_r <= magw(src_b);
          gk_r <= '0;
        end
        OP_GCD_STEP: begin
          if (gx_r == '0) begin
            gx_r <= gy_r; gy_r <= '0;
          end else if (gy_r != '0) begin
            if (!gx_r[0] && !gy_r[0]) begin
              gx_r <= gx_r >> 1; gy_r <= gy_r >> 1; gk_r <= gk_r + CW'(1);
            end else if (!gx_r[0]) gx_r <= gx_r >> 1;
            else if (!gy_r[0]) gy_r <= gy_r >> 1;
            else if (gx_r >= gy_r) gx_r <= (gx_r - gy_r) >> 1;
            else gy_r <= (gy_r - gx_r) >> 1;
          end
        end
        OP_DIV_INIT: begin
          dq_r   <= magw(div_src);
          dneg_r <= div_src[WW-1];
          drem_r <= '0;
          ddiv_r <= g_val;
          dcnt_r <= CW'(WW);
        end
        OP_DIV_STEP: begin
          if (dcnt_r != '0) begin
            dcnt_r <= dcnt_r - CW'(1);
            if (!rem_sub[WW-1] && rem_sh >= ddiv_r) begin
              drem_r <= rem_sub; dq_r <= {dq_r[WW-2:0], 1'b1};
            end else begin
              drem_r <= rem_sh; dq_r <= {dq_r[WW-2:0], 1'b0};
            end
          end
        end
        OP_DIV_SAVE: begin
          case (cmd.sel)
            3'd0: an_r <= (W+1)'(dneg_r ? -dq_r : dq_r);
            3'd1: ad_r <= (W+1)'(dneg_r ? -dq_r : dq_r);
            3'd2: bn_r <= (W+1)'(dneg_r ? -dq_r : dq_r);
            3'd3: bd_r <= (W+1)'(dneg_r ? -dq_r : dq_r);
            3'd4: n_r  <= dneg_r ? -dq_r : dq_r;
            default: d_r <= dneg_r ? -dq_r : dq_r;
          endcase
        end
        OP_MUL1: n_r <= prod;
        OP_MUL2: d_r <= prod;
        OP_ADDSUB: begin
          n_r <= sum;
          d_r <= ext(ad_r) * ext(bd_r);
        end
        OP_CMP: begin
          // n_r = an*bd, d_r = bn*ad
          if (ad_r[W] != bd_r[W])
            ord_r <= (d_r < n_r) ? ORD_LESS : (d_r > n_r ? ORD_GREATER : ORD_EQUAL);
          else
            ord_r <= (n_r < d_r) ? ORD_LESS : (n_r > d_r ? ORD_GREATER : ORD_EQUAL);
          n_r <= '0; d_r <= WW'(1);
        end
        OP_FINISH: begin
          st_r <= st_nxt;
          n_r  <= fn;
          d_r  <= fd;
        end
        default: ;
      endcase
      if (cmd.op == OP_GCD_INIT && cmd.sel == 3'd4 &&
          !(in_rng(n_r, lo_lim, hi_lim) && in_rng(d_r, lo_lim, hi_lim)))
        st_r <= ST_OVF;
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (st_r == ST_OK && !(in_rng(fn, lo_lim, hi_lim) && in_rng(fd, lo_lim, hi_lim)))
      st_nxt = ST_OVF;
  end

  assign stat.gcd_done = (gy_r == '0) && (gx_r != '0 || gy_r == '0);
  assign stat.div_done = (dcnt_r == '0);
  assign stat.early    = early_r || (st_r != ST_OK);

  always_comb begin
    result.status  = st_r;
    result.order   = (st_r == ST_OK) ? ord_r : ORD_LESS;
    if (st_r == ST_OK) begin
      result.res_num = FIELD_BITS'(n_r[W-1:0]);
      result.res_den = FIELD_BITS'(d_r[W-1:0]);
      if (W < FIELD_BITS) begin
        result.res_num = FIELD_BITS'(signed'(n_r[W-1:0]));
        result.res_den = FIELD_BITS'(signed'(d_r[W-1:0]));
      end
    end else begin
      result.res_num = '0;
      result.res_den = FIELD_BITS'(1);
    end
  end

endmodule

>>> hdl/rau_ctrl.sv
// controller sequencing gcd, division and multiply steps
module rau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         mode,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_GINIT, S_GSTEP, S_DINIT, S_DSTEP, S_DSAVE,
    S_MUL1, S_MUL2, S_ADD, S_CMP, S_RINIT, S_FIN, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [2:0] job_r, job_nxt;   // step index in the divide plan
  logic done_r, done_nxt;

  // each job: gcd pair, then quotient target slot
  // mul: pair0 slots 0,3 ; pair1 slots 1,2 ; div: pair2 slots 0,2 ; pair3 slots 1,3
  // final reduce: pair4 slots 4,5
  logic [2:0] gpair, dslot;
  always_comb begin
    gpair = 3'd4;
    dslot = 3'd4;
    case (job_r)
      3'd0: begin gpair = (mode_r == MODE_MUL) ? 3'd0 : 3'd2; dslot = 3'd0; end
      3'd1: begin gpair = (mode_r == MODE_MUL) ? 3'd0 : 3'd2;
                  dslot = (mode_r == MODE_MUL) ? 3'd3 : 3'd2; end
      3'd2: begin gpair = (mode_r == MODE_MUL) ? 3'd1 : 3'd3;
                  dslot = (mode_r == MODE_MUL) ? 3'd1 : 3'd1; end
      3'd3: begin gpair = (mode_r == MODE_MUL) ? 3'd1 : 3'd3;
                  dslot = (mode_r == MODE_MUL) ? 3'd2 : 3'd3; end
      3'd4: begin gpair = 3'd4; dslot = 3'd4; end
      default: begin gpair = 3'd4; dslot = 3'd5; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    job_nxt   = job_r;
    done_nxt  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.sel   = 3'd0;
    unique case (state_r)
      // no load while the previous result is still on the outputs
      S_IDLE: if (start && !done_r) begin
        cmd.op = OP_LOAD; mode_nxt = mode; state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.early) state_nxt = S_DONE;
        else if (mode_r == MODE_ADD || mode_r == MODE_SUB) state_nxt = S_MUL1;
        else if (mode_r == MODE_CMP) state_nxt = S_MUL1;
        else if (mode_r == MODE_INV) begin job_nxt = 3'd4; state_nxt = S_GINIT; end
        else begin job_nxt = 3'd0; state_nxt = S_GINIT; end
      end
      S_GINIT: begin
        cmd.op = OP_GCD_INIT; cmd.sel = gpair; state_nxt = S_GSTEP;
      end
      S_GSTEP: begin
        cmd.op = OP_GCD_STEP;
        if (stat.early) state_nxt = S_DONE;
        else if (stat.gcd_done) state_nxt = S_DINIT;
      end
      S_DINIT: begin cmd.op = OP_DIV_INIT; cmd.sel = dslot; state_nxt = S_DSTEP; end
      S_DSTEP: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_done) state_nxt = S_DSAVE;
      end
      S_DSAVE: begin
        cmd.op = OP_DIV_SAVE; cmd.sel = dslot;
        job_nxt = job_r + 3'd1;
        if (job_r == 3'd5) state_nxt = S_FIN;
        else if (job_r == 3'd3) state_nxt = S_MUL1;
        else if (job_r == 3'd0 || job_r == 3'd2 || job_r == 3'd4) state_nxt = S_DINIT;
        else state_nxt = S_GINIT;
      end
      S_MUL1: begin cmd.op = OP_MUL1; state_nxt = S_MUL2; end
      S_MUL2: begin
        cmd.op = OP_MUL2;
        if (mode_r == MODE_CMP) state_nxt = S_CMP;
        else if (mode_r == MODE_ADD || mode_r == MODE_SUB) state_nxt = S_ADD;
        else state_nxt = S_RINIT;
      end
      S_ADD: begin cmd.op = OP_ADDSUB; state_nxt = S_RINIT; end
      S_CMP: begin cmd.op = OP_CMP; state_nxt = S_DONE; end
      S_RINIT: begin job_nxt = 3'd4; state_nxt = S_GINIT; end
      S_FIN: begin cmd.op = OP_FINISH; state_nxt = S_DONE; end
      S_DONE: begin done_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= '0;
      job_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      job_r   <= job_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE) || done_r;
  assign done = done_r;

`ifndef SYNTHESIS
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held two cycles");
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) == S_DONE) else $error("done without finish");
  a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> busy) else $error("idle flag while working");
`endif

endmodule

>>> hdl/rational_arithmetic_unit.sv
// rational arithmetic unit top level
// each restoring division yields 66 quotient bits
// add, subtract and invert: one gcd and two divisions in the worst case
// multiply and divide: three gcds and six divisions in the worst case
// one transaction at a time, next accepted the cycle after the result strobe;
// results appear on out_valid for one cycle and cannot be stalled;
// synchronous active-low reset returns the controller to idle
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_valid,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;
  logic      done;
  rau_out_t  res;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .mode(in_data.mode),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd),
    .stat(stat), .result(res)
  );

  assign out_valid = done;
  assign out_data  = res;

endmodule

>>> dv/rational_arithmetic_unit_test.sv
// self-checking testbench for the rational arithmetic unit
module rational_arithmetic_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rau_in_t  in_data = '0;
  logic     out_valid;
  rau_out_t out_data;

  rau_in_t  pending_ops[$];
  rau_out_t expected_results[$];
  int       error_count = 0;
  int       op_count = 0;
  int       result_count = 0;
  int       sender_idle_pct = 0;
  logic     stim_done = 1'b0;

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] magnitude(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint gcd_of(longint x, longint y);
    logic [63:0] p, q, t;
    p = magnitude(x);
    q = magnitude(y);
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p == 0 ? 1 : longint'(p);
  endfunction

  function automatic bit fits_word(longint x);
    return x >= -64'sd2147483648 && x <= 64'sd2147483647;
  endfunction

  function automatic logic [1:0] reduce_frac(longint n, longint d,
                                             output longint rn, output longint rd);
    longint g;
    g = gcd_of(n, d);
    n = n / g;
    d = d / g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (!fits_word(n) || !fits_word(d)) return ST_OVF;
    rn = n;
    rd = d;
    return ST_OK;
  endfunction

  function automatic logic [1:0] check_reduce(longint n, longint d,
                                              output longint rn, output longint rd);
    if (!fits_word(n) || !fits_word(d)) return ST_OVF;
    return reduce_frac(n, d, rn, rd);
  endfunction

  function automatic rau_out_t predict_fraction(rau_in_t x);
    longint an, ad, bn, bd, rn, rd, n, d, t2, lhs, rhs, g1, g2;
    logic [1:0] ord, st;
    logic [2:0] m;
    rau_out_t r;
    m = x.mode;
    an = x.a_num; ad = x.a_den; bn = x.b_num; bd = x.b_den;
    rn = 0; rd = 1; ord = ORD_LESS; st = ST_OK;
    if (m <= MODE_INV && (ad == 0 || (m != MODE_INV && bd == 0))) begin
      st = ST_DIV0;
    end else if (m == MODE_ADD || m == MODE_SUB) begin
      if (bn == 0) begin
        rn = an; rd = ad;
      end else if (m == MODE_ADD && an == 0) begin
        rn = bn; rd = bd;
      end else begin
        // the 64-bit sum overflows only when both products equal 2**62
        t2 = bn * ad;
        if (m == MODE_SUB) t2 = -t2;
        n = an * bd + t2;
        d = ad * bd;
        st = check_reduce(n, d, rn, rd);
      end
    end else if (m == MODE_MUL) begin
      if (an != 0 && bn != 0) begin
        g1 = gcd_of(an, bd); g2 = gcd_of(ad, bn);
        n = (an / g1) * (bn / g2);
        d = (ad / g2) * (bd / g1);
        st = check_reduce(n, d, rn, rd);
      end
    end else if (m == MODE_DIV) begin
      if (bn == 0) st = ST_DIV0;
      else begin
        g1 = gcd_of(an, bn); g2 = gcd_of(ad, bd);
        n = (an / g1) * (bd / g2);
        d = (ad / g2) * (bn / g1);
        st = check_reduce(n, d, rn, rd);
      end
    end else if (m == MODE_CMP) begin
      lhs = an * bd; rhs = bn * ad;
      if ((ad < 0) != (bd < 0)) begin
        n = lhs; lhs = rhs; rhs = n;
      end
      ord = lhs < rhs ? ORD_LESS : (lhs > rhs ? ORD_GREATER : ORD_EQUAL);
    end else if (m == MODE_INV) begin
      if (an == 0) st = ST_DIV0;
      else st = reduce_frac(ad, an, rn, rd);
    end
    if (st != ST_OK) begin
      rn = 0; rd = 1; ord = ORD_LESS;
    end
    r.res_num = rn[31:0];
    r.res_den = rd[31:0];
    r.order = ord;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 131071)) - 65536);
      4: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(logic [2:0] m, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    rau_in_t x;
    x.mode = m; x.a_num = an; x.a_den = ad; x.b_num = bn; x.b_den = bd;
    pending_ops.push_back(x);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_results.push_back(predict_fraction(in_data));
      op_count++;
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        in_data <= pending_ops.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_ops.size() > 0 &&
                 $urandom_range(0, 99) >= sender_idle_pct) begin
      in_data <= pending_ops.pop_front();
      start <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    rau_out_t e;
    if (rst_n && out_valid) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("result with no transaction outstanding: %h", out_data);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.res_num !== e.res_num) begin
          $error("res_num expected %0d actual %0d", e.res_num, out_data.res_num);
          error_count++;
        end
        if (out_data.res_den !== e.res_den) begin
          $error("res_den expected %0d actual %0d", e.res_den, out_data.res_den);
          error_count++;
        end
        if (out_data.order !== e.order) begin
          $error("order expected %0d actual %0d", e.order, out_data.order);
          error_count++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    int idle_plan[4];
    int k;
    logic [2:0] m;
    logic [31:0] ad, bd;
    idle_plan = '{0, 80, 0, 11};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every mode, fast paths and error cases
    queue_op(MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    queue_op(MODE_SUB, 32'h8000_0000, 1, 1, 1);
    queue_op(MODE_ADD, 5, -10, 0, 7);
    queue_op(MODE_SUB, -6, 4, 0, -3);
    queue_op(MODE_ADD, 0, 9, -6, -4);
    queue_op(MODE_ADD, 1, 0, 2, 3);
    queue_op(MODE_SUB, 1, 2, 2, 0);
    queue_op(MODE_MUL, 0, 5, 3, 7);
    queue_op(MODE_MUL, 6, -4, 10, 9);
    queue_op(MODE_MUL, 32'h8000_0000, 1, -1, 1);
    queue_op(MODE_DIV, 3, 4, 0, 5);
    queue_op(MODE_DIV, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 3);
    queue_op(MODE_DIV, 2, 3, 4, -9);
    queue_op(MODE_CMP, 1, 2, 2, 4);
    queue_op(MODE_CMP, 1, -2, 1, 3);
    queue_op(MODE_CMP, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_op(MODE_INV, 0, 5, 0, 0);
    queue_op(MODE_INV, 4, -6, 0, 0);
    queue_op(MODE_INV, 32'h8000_0000, 1, 0, 0);
    queue_op(MODE_INV, 3, 0, 7, 7);
    queue_op(3'd6, 1, 1, 1, 1);
    queue_op(3'd7, 32'hffff_ffff, 0, 32'hffff_ffff, 0);
    queue_op(MODE_CMP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_plan[phase];
      k = (phase == 0) ? 100 : 110;
      repeat (k) begin
        m = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7))
                                        : 3'($urandom_range(0, 5));
        ad = pick_value();
        bd = pick_value();
        // mostly nonzero denominators so the arithmetic is reached
        if (ad == 0 && $urandom_range(0, 3) != 0) ad = 1;
        if (bd == 0 && $urandom_range(0, 3) != 0) bd = 32'hffff_ffff;
        queue_op(m, pick_value(), ad, pick_value(), bd);
      end
      wait (pending_ops.size() == 0 && !start && expected_results.size() == 0);
    end
    repeat (20) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("covered %0d transactions in all six modes plus unused codes,", op_count);
    $display("%0d results checked across four idle phases", result_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> files.f
hdl/rau_pkg.sv
hdl/rau_datapath.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_test.sv
